// File: rtl/core/dwc3_pkg.sv
package dwc3_pkg;

	// Field widths of the request and result channels.
	localparam int ACTION_W   = 2;
	localparam int INDEX_W    = 10;
	localparam int SAMPLE_W   = 8;
	localparam int BIAS_W     = 32;
	localparam int ACT_OUT_W  = 7;
	localparam int CHAN_OUT_W = 6;
	localparam int CFG_W      = 7;

	// Packing of the request tdata, first field in the lowest bits.
	localparam int INDEX_LSB   = 0;
	localparam int SAMPLE_LSB  = INDEX_LSB + INDEX_W;
	localparam int BIAS_LSB    = SAMPLE_LSB + SAMPLE_W;
	localparam int IN_DATA_W   = ((BIAS_LSB + BIAS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W  = ((ACT_OUT_W + CHAN_OUT_W + 7) / 8) * 8;

	// Kernel geometry and requantisation.
	localparam int KDIM   = 3;
	localparam int TAPS   = 9;
	localparam int TAP_W  = 4;
	localparam int WSHIFT = 8;
	localparam int PROD_W = 16;

	// Division of a 10-bit load index by nine: (x * 911) >> 13 is exact below 1170.
	localparam int DIV9_MUL   = 911;
	localparam int DIV9_SHIFT = 13;
	localparam int DIV9_PROD_W = INDEX_W + 10;
	localparam int DIV9_Q_W   = DIV9_PROD_W - DIV9_SHIFT;

	// Result buffer.
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;
	localparam int FIFO_CW    = 4;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_WEIGHT = 2'd1,
		ACT_BIAS   = 2'd2
	} action_t;

	typedef struct packed {
		logic                  frame_end;
		logic [CHAN_OUT_W-1:0] channel;
		logic [ACT_OUT_W-1:0]  activation;
	} result_t;

	// Window edge flags of one sample.
	typedef struct packed {
		logic row_ge2;
		logic row_ge1;
		logic col_ge2;
		logic col_ge1;
	} edge_mask_t;

endpackage

// File: rtl/core/depthwise_conv3x3_int8_stream_top.sv
// Channel   Direction  Handshake                   Payload
// s_axis    in         s_axis_tvalid/tready        tuser action; tdata index, sample, bias
// m_axis    out        m_axis_tvalid/tready        tdata activation, channel; tlast frame end
// cfg       in         cfg_valid/cfg_ready         cfg_data channels in use
//
// One request is taken per cycle, outside the stalls named below; a sample's result
// passes the memory read, product and partial-sum registers into an eight-entry buffer.
// The rate is set by the line and window memories, each read once and written once
// per cycle; a sample that follows one of the same channel gets its window forwarded.
// After reset the line store and the window store are cleared, one entry a cycle,
// over all MAX_CHANNELS * FRAME_SIZE line addresses, during which no request is taken.
// Outside that pass, requests stall only when the buffer plus the samples in flight would overfill it.
module depthwise_conv3x3_int8_stream_top #(
	parameter int FRAME_SIZE   = 64,
	parameter int MAX_CHANNELS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata: index [9:0], sample [17:10], bias_value [49:18], zeros above
	input  logic [dwc3_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// tuser: action [1:0]
	input  logic [dwc3_pkg::ACTION_W-1:0]       s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// tdata: activation [6:0], channel [12:7], zeros above
	output logic [dwc3_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dwc3_pkg::CFG_W-1:0]          cfg_data
);

	localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int POS_W      = $clog2(FRAME_SIZE);
	localparam int LINE_DEPTH = MAX_CHANNELS * FRAME_SIZE;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);
	localparam int WT_DEPTH   = MAX_CHANNELS * dwc3_pkg::TAPS;
	localparam int WIN_W      = dwc3_pkg::KDIM * 2 * dwc3_pkg::SAMPLE_W;
	localparam int EFF_RESET  = (MAX_CHANNELS < 64) ? MAX_CHANNELS : 64;

	// Memories.
	logic [2*dwc3_pkg::SAMPLE_W-1:0]                 line_mem [LINE_DEPTH];
	logic [WIN_W-1:0]                                win_mem  [MAX_CHANNELS];
	logic [dwc3_pkg::TAPS-1:0][dwc3_pkg::SAMPLE_W-1:0] wt_mem [MAX_CHANNELS];
	logic [dwc3_pkg::BIAS_W-1:0]                     bias_mem [MAX_CHANNELS];

	// Control state.
	logic                 clr_busy_q;
	logic [LINE_AW-1:0]   clr_addr_q;
	logic [CH_W:0]        eff_q;
	logic [CH_W-1:0]      ch_q;
	logic [POS_W-1:0]     col_q;
	logic [POS_W-1:0]     row_q;

	// Request decode.
	dwc3_pkg::action_t               act;
	logic [dwc3_pkg::INDEX_W-1:0]    req_index;
	logic [dwc3_pkg::SAMPLE_W-1:0]   req_sample;
	logic [dwc3_pkg::BIAS_W-1:0]     req_bias;
	logic                            in_acc;
	logic                            smp_acc;
	logic                            wt_we;
	logic                            bias_we;
	logic [dwc3_pkg::DIV9_PROD_W-1:0] div9_prod;
	logic [CH_W-1:0]                 wt_ch;
	logic [dwc3_pkg::TAP_W-1:0]      wt_tap;
	logic [LINE_AW-1:0]              line_addr;
	logic                            last_ch;
	logic                            last_col;
	logic                            last_row;

	// Stage 1.
	logic                            valid_s1;
	logic [CH_W-1:0]                 ch_s1;
	logic [dwc3_pkg::SAMPLE_W-1:0]   sample_s1;
	dwc3_pkg::edge_mask_t            mask_s1;
	logic                            fe_s1;
	logic                            fwd_s1;
	logic [LINE_AW-1:0]              line_addr_s1;
	logic [2*dwc3_pkg::SAMPLE_W-1:0] line_rd_s1;
	logic [WIN_W-1:0]                win_rd_s1;
	logic [dwc3_pkg::TAPS-1:0][dwc3_pkg::SAMPLE_W-1:0] wt_rd_s1;
	logic [dwc3_pkg::BIAS_W-1:0]     bias_rd_s1;
	logic [WIN_W-1:0]                win_last_q;
	logic [WIN_W-1:0]                win_cur;
	logic [WIN_W-1:0]                win_new;
	logic [dwc3_pkg::KDIM-1:0][dwc3_pkg::SAMPLE_W-1:0] newcol;
	logic signed [dwc3_pkg::PROD_W-1:0] prod [dwc3_pkg::TAPS];

	// Stage 2.
	logic                            valid_s2;
	logic [CH_W-1:0]                 ch_s2;
	logic                            fe_s2;
	logic signed [dwc3_pkg::PROD_W-1:0] prod_s2 [dwc3_pkg::TAPS];
	logic [dwc3_pkg::PROD_W-1:0]     bias_s2;

	// Stage 3.
	logic                            valid_s3;
	logic [CH_W-1:0]                 ch_s3;
	logic                            fe_s3;
	logic [dwc3_pkg::PROD_W-1:0]     part_s3 [dwc3_pkg::KDIM];
	logic [dwc3_pkg::PROD_W-1:0]     acc_sum;
	logic [dwc3_pkg::SAMPLE_W-1:0]   q_val;
	dwc3_pkg::result_t               res;

	// Result buffer.
	dwc3_pkg::result_t               fifo_mem [dwc3_pkg::FIFO_DEPTH];
	logic [dwc3_pkg::FIFO_AW-1:0]    fifo_wr_q;
	logic [dwc3_pkg::FIFO_AW-1:0]    fifo_rd_q;
	logic [dwc3_pkg::FIFO_CW-1:0]    fifo_cnt_q;
	logic [dwc3_pkg::FIFO_CW-1:0]    credit_use;
	logic                            push;
	logic                            pop;
	dwc3_pkg::result_t               head;

	// Request fields and handshake.
	assign act        = dwc3_pkg::action_t'(s_axis_tuser);
	assign req_index  = s_axis_tdata[dwc3_pkg::INDEX_LSB +: dwc3_pkg::INDEX_W];
	assign req_sample = s_axis_tdata[dwc3_pkg::SAMPLE_LSB +: dwc3_pkg::SAMPLE_W];
	assign req_bias   = s_axis_tdata[dwc3_pkg::BIAS_LSB +: dwc3_pkg::BIAS_W];

	assign credit_use = fifo_cnt_q + dwc3_pkg::FIFO_CW'(valid_s1) +
		dwc3_pkg::FIFO_CW'(valid_s2) + dwc3_pkg::FIFO_CW'(valid_s3);
	assign s_axis_tready = !clr_busy_q &&
		(credit_use < dwc3_pkg::FIFO_CW'(dwc3_pkg::FIFO_DEPTH));
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	// Decode the action of an accepted request.
	always_comb begin
		smp_acc = 1'b0;
		wt_we   = 1'b0;
		bias_we = 1'b0;
		unique case (act)
			dwc3_pkg::ACT_SAMPLE: smp_acc = in_acc;
			dwc3_pkg::ACT_WEIGHT: wt_we   = in_acc && (int'(req_index) < WT_DEPTH);
			dwc3_pkg::ACT_BIAS:   bias_we = in_acc && (int'(req_index) < MAX_CHANNELS);
			default: ;
		endcase
	end

	// Weight address split into channel and tap by a reciprocal multiply.
	assign div9_prod = dwc3_pkg::DIV9_PROD_W'(req_index) *
		dwc3_pkg::DIV9_PROD_W'(dwc3_pkg::DIV9_MUL);
	assign wt_ch  = CH_W'(div9_prod[dwc3_pkg::DIV9_PROD_W-1:dwc3_pkg::DIV9_SHIFT]);
	assign wt_tap = dwc3_pkg::TAP_W'(req_index -
		dwc3_pkg::INDEX_W'(div9_prod[dwc3_pkg::DIV9_PROD_W-1:dwc3_pkg::DIV9_SHIFT]) *
		dwc3_pkg::INDEX_W'(dwc3_pkg::TAPS));

	// Position of the current sample.
	assign line_addr = LINE_AW'(int'(ch_q) * FRAME_SIZE + int'(col_q));
	assign last_ch   = ({1'b0, ch_q} + (CH_W+1)'(1)) >= eff_q;
	assign last_col  = (int'(col_q) == FRAME_SIZE - 1);
	assign last_row  = (int'(row_q) == FRAME_SIZE - 1);

	// Clearing pass, channel register and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			eff_q      <= (CH_W+1)'(EFF_RESET);
			ch_q       <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else begin
			if (clr_busy_q) begin
				if (clr_addr_q == LINE_AW'(LINE_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
				clr_addr_q <= clr_addr_q + LINE_AW'(1);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_data == '0) begin
					eff_q <= (CH_W+1)'(1);
				end else if (int'(cfg_data) > MAX_CHANNELS) begin
					eff_q <= (CH_W+1)'(MAX_CHANNELS);
				end else begin
					eff_q <= (CH_W+1)'(cfg_data);
				end
			end
			if (smp_acc) begin
				if (!last_ch) begin
					ch_q <= ch_q + CH_W'(1);
				end else begin
					ch_q <= '0;
					if (!last_col) begin
						col_q <= col_q + POS_W'(1);
					end else begin
						col_q <= '0;
						row_q <= last_row ? '0 : row_q + POS_W'(1);
					end
				end
			end
		end
	end

	// Line store: both earlier rows of one channel and column in one word.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			line_mem[clr_addr_q] <= '0;
		end else if (valid_s1) begin
			line_mem[line_addr_s1] <= {sample_s1, newcol[1]};
		end
		line_rd_s1 <= line_mem[line_addr];
	end

	// Window store: two held columns of three rows for each channel.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			if (int'(clr_addr_q) < MAX_CHANNELS) begin
				win_mem[CH_W'(clr_addr_q)] <= '0;
			end
		end else if (valid_s1) begin
			win_mem[ch_s1] <= win_new;
		end
		win_rd_s1 <= win_mem[ch_q];
	end

	// Weight and bias stores, written by load requests.
	always_ff @(posedge clk) begin
		if (wt_we) begin
			wt_mem[wt_ch][wt_tap] <= req_sample;
		end
		wt_rd_s1 <= wt_mem[ch_q];
	end

	always_ff @(posedge clk) begin
		if (bias_we) begin
			bias_mem[CH_W'(req_index)] <= req_bias;
		end
		bias_rd_s1 <= bias_mem[ch_q];
	end

	// Stage 1: assemble the window, write it back and form the nine products.
	always_comb begin
		newcol[0] = line_rd_s1[dwc3_pkg::SAMPLE_W-1:0];
		newcol[1] = line_rd_s1[2*dwc3_pkg::SAMPLE_W-1:dwc3_pkg::SAMPLE_W];
		newcol[2] = sample_s1;
		win_cur   = fwd_s1 ? win_last_q : win_rd_s1;
		for (int r = 0; r < dwc3_pkg::KDIM; r++) begin
			win_new[r*16 +: 8]     = win_cur[r*16+8 +: 8];
			win_new[r*16+8 +: 8]   = newcol[r];
		end
	end

	always_comb begin
		logic [dwc3_pkg::KDIM-1:0] row_ok;
		logic [dwc3_pkg::KDIM-1:0] col_ok;
		logic [dwc3_pkg::SAMPLE_W-1:0] pix;
		row_ok = {1'b1, mask_s1.row_ge1, mask_s1.row_ge2};
		col_ok = {1'b1, mask_s1.col_ge1, mask_s1.col_ge2};
		for (int r = 0; r < dwc3_pkg::KDIM; r++) begin
			for (int k = 0; k < dwc3_pkg::KDIM; k++) begin
				if (k == 2) begin
					pix = newcol[r];
				end else begin
					pix = win_cur[r*16 + k*8 +: 8];
				end
				if (!(row_ok[r] && col_ok[k])) begin
					pix = '0;
				end
				prod[r*dwc3_pkg::KDIM + k] = $signed(pix) *
					$signed(wt_rd_s1[r*dwc3_pkg::KDIM + k]);
			end
		end
	end

	// Stage 3: final sum, requantisation and ReLU.
	assign acc_sum = part_s3[0] + part_s3[1] + part_s3[2];
	assign q_val   = acc_sum[dwc3_pkg::WSHIFT +: dwc3_pkg::SAMPLE_W];
	assign res.activation = q_val[dwc3_pkg::SAMPLE_W-1] ? '0 :
		q_val[dwc3_pkg::ACT_OUT_W-1:0];
	assign res.channel    = dwc3_pkg::CHAN_OUT_W'(ch_s3);
	assign res.frame_end  = fe_s3;

	// Pipeline valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= smp_acc;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		ch_s1           <= ch_q;
		sample_s1       <= req_sample;
		mask_s1.row_ge2 <= (row_q >= POS_W'(2));
		mask_s1.row_ge1 <= (row_q != '0);
		mask_s1.col_ge2 <= (col_q >= POS_W'(2));
		mask_s1.col_ge1 <= (col_q != '0);
		fe_s1           <= last_ch && last_col && last_row;
		fwd_s1          <= valid_s1 && (ch_s1 == ch_q);
		line_addr_s1    <= line_addr;
		if (valid_s1) begin
			win_last_q <= win_new;
		end

		ch_s2   <= ch_s1;
		fe_s2   <= fe_s1;
		bias_s2 <= bias_rd_s1[dwc3_pkg::PROD_W-1:0];
		for (int t = 0; t < dwc3_pkg::TAPS; t++) begin
			prod_s2[t] <= prod[t];
		end

		ch_s3      <= ch_s2;
		fe_s3      <= fe_s2;
		part_s3[0] <= prod_s2[0] + prod_s2[1] + prod_s2[2];
		part_s3[1] <= prod_s2[3] + prod_s2[4] + prod_s2[5];
		part_s3[2] <= prod_s2[6] + prod_s2[7] + prod_s2[8] + bias_s2;
	end

	// Result buffer.
	assign push = valid_s3;
	assign pop  = m_axis_tvalid && m_axis_tready;
	assign head = fifo_mem[fifo_rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[fifo_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_wr_q  <= '0;
			fifo_rd_q  <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) begin
				fifo_wr_q <= fifo_wr_q + dwc3_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				fifo_rd_q <= fifo_rd_q + dwc3_pkg::FIFO_AW'(1);
			end
			if (push && !pop) begin
				fifo_cnt_q <= fifo_cnt_q + dwc3_pkg::FIFO_CW'(1);
			end else if (!push && pop) begin
				fifo_cnt_q <= fifo_cnt_q - dwc3_pkg::FIFO_CW'(1);
			end
		end
	end

	assign m_axis_tvalid = (fifo_cnt_q != '0);
	assign m_axis_tdata  = {{(dwc3_pkg::OUT_DATA_W - dwc3_pkg::ACT_OUT_W -
		dwc3_pkg::CHAN_OUT_W){1'b0}}, head.channel, head.activation};
	assign m_axis_tlast  = head.frame_end;

`ifndef SYNTHESIS
	// A result must never arrive at a full buffer that is not being read in the same cycle.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> fifo_cnt_q != dwc3_pkg::FIFO_CW'(dwc3_pkg::FIFO_DEPTH))
		else $error("result buffer overflow");

	// Back-to-back samples of one channel must take the forwarded window.
	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && (ch_s1 == ch_s2) |-> fwd_s1)
		else $error("window forwarding missed");

	// The pixel position stays inside the frame.
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(col_q) < FRAME_SIZE) && (int'(row_q) < FRAME_SIZE))
		else $error("pixel position out of frame");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int FRAME_SIZE   = 64;
	localparam int MAX_CHANNELS = 64;
	localparam int WEIGHT_COUNT = MAX_CHANNELS * dwc3_pkg::TAPS;
	localparam int STALL_LIMIT  = 20000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_PHASES = 3;
	localparam int PHASE_ITEMS  = 150;
	localparam int STALL_ITEMS  = 150;
	localparam int HOLD_AFTER   = 20;
	localparam int REPORT_LIMIT = 10;
	localparam logic [dwc3_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [dwc3_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	logic [dwc3_pkg::ACTION_W-1:0]   s_axis_tuser;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [dwc3_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                            m_axis_tlast;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [dwc3_pkg::CFG_W-1:0]      cfg_data;

	// Shadow copy of the convolution state.
	bit [7:0]  line_mem [MAX_CHANNELS][2][FRAME_SIZE];
	bit [7:0]  window_mem [MAX_CHANNELS][dwc3_pkg::KDIM][2];
	bit [7:0]  weight_mem [WEIGHT_COUNT];
	bit [31:0] bias_mem [MAX_CHANNELS];
	int        row_pos;
	int        col_pos;
	int        chan_pos;
	int        channels_reg = 64;

	dwc3_pkg::result_t pending_results[$];
	int        requests_sent;
	int        results_checked;
	int        frame_ends_due;
	int        mismatches;
	int        idle_cycles;
	bit        gaps_on = 1'b1;
	bit        sink_hold = 1'b0;

	always #5 clk = ~clk;

	depthwise_conv3x3_int8_stream_top #(
		.FRAME_SIZE  (FRAME_SIZE),
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// Applies one request to the shadow state; returns 1 when it yields a result.
	function automatic bit predict_activation(input logic [dwc3_pkg::ACTION_W-1:0] act,
			input logic [dwc3_pkg::INDEX_W-1:0] idx,
			input logic [dwc3_pkg::SAMPLE_W-1:0] smp,
			input logic [dwc3_pkg::BIAS_W-1:0] bval, output dwc3_pkg::result_t res);
		bit [7:0] column [dwc3_pkg::KDIM];
		bit [7:0] win [dwc3_pkg::KDIM][dwc3_pkg::KDIM];
		logic signed [7:0] px;
		logic signed [7:0] wt;
		logic signed [15:0] prod;
		logic [31:0] acc;
		logic [7:0] q;
		int c, w, h, n;
		bit last_ch, last_px;
		res = '0;
		if (act == dwc3_pkg::ACT_WEIGHT) begin
			if (idx < WEIGHT_COUNT)
				weight_mem[idx] = smp;
			return 1'b0;
		end
		if (act == dwc3_pkg::ACT_BIAS) begin
			if (idx < MAX_CHANNELS)
				bias_mem[idx] = bval;
			return 1'b0;
		end
		if (act != dwc3_pkg::ACT_SAMPLE)
			return 1'b0;

		c = chan_pos;
		w = col_pos;
		h = row_pos;

		// Shift the new sample into the line store and the window.
		column[0] = line_mem[c][0][w];
		column[1] = line_mem[c][1][w];
		column[2] = smp;
		line_mem[c][0][w] = line_mem[c][1][w];
		line_mem[c][1][w] = smp;
		for (int r = 0; r < dwc3_pkg::KDIM; r++) begin
			win[r][0] = window_mem[c][r][0];
			win[r][1] = window_mem[c][r][1];
			win[r][2] = column[r];
			window_mem[c][r][0] = window_mem[c][r][1];
			window_mem[c][r][1] = column[r];
		end

		// Wrapping sum of bias and products; positions above or left of the frame are zero.
		acc = bias_mem[c];
		for (int r = 0; r < dwc3_pkg::KDIM; r++) begin
			for (int k = 0; k < dwc3_pkg::KDIM; k++) begin
				px = (h + r >= 2 && w + k >= 2) ? win[r][k] : 8'h00;
				wt = weight_mem[c * dwc3_pkg::TAPS + r * dwc3_pkg::KDIM + k];
				prod = px * wt;
				acc += {{16{prod[15]}}, prod};
			end
		end

		// Keep bits 15..8, then clamp negatives to zero.
		q = acc[dwc3_pkg::WSHIFT +: 8];
		res.activation = q[7] ? '0 : q[dwc3_pkg::ACT_OUT_W-1:0];
		res.channel = c[dwc3_pkg::CHAN_OUT_W-1:0];

		n = (channels_reg == 0) ? 1 :
			(channels_reg > MAX_CHANNELS) ? MAX_CHANNELS : channels_reg;
		last_ch = (c + 1 >= n);
		last_px = (w + 1 >= FRAME_SIZE) && (h + 1 >= FRAME_SIZE);
		res.frame_end = last_ch && last_px;

		// Advance channel, column and row counters.
		if (!last_ch) begin
			chan_pos = c + 1;
		end else begin
			chan_pos = 0;
			if (w + 1 < FRAME_SIZE) begin
				col_pos = w + 1;
			end else begin
				col_pos = 0;
				row_pos = (h + 1 < FRAME_SIZE) ? h + 1 : 0;
			end
		end
		return 1'b1;
	endfunction

	// Offers one request, with random gaps, and records its expected result on acceptance.
	task automatic send_request(input logic [dwc3_pkg::ACTION_W-1:0] act,
			input logic [dwc3_pkg::INDEX_W-1:0] idx,
			input logic [dwc3_pkg::SAMPLE_W-1:0] smp,
			input logic [dwc3_pkg::BIAS_W-1:0] bval);
		dwc3_pkg::result_t res;
		while (gaps_on && $urandom_range(99) < 22) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= dwc3_pkg::IN_DATA_W'({bval, smp, idx});
		do
			@(posedge clk);
		while (!s_axis_tready);
		requests_sent++;
		if (predict_activation(act, idx, smp, bval, res)) begin
			pending_results.push_back(res);
			if (res.frame_end)
				frame_ends_due++;
		end
		@(negedge clk);
	endtask

	// A pixel sample; the index and bias fields carry random filler.
	task automatic send_sample(input logic [dwc3_pkg::SAMPLE_W-1:0] value);
		send_request(dwc3_pkg::ACT_SAMPLE, dwc3_pkg::INDEX_W'($urandom), value, $urandom);
	endtask

	// Writes the channel count once the block has gone quiet.
	task automatic write_channels(input logic [dwc3_pkg::CFG_W-1:0] value);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		channels_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Every weight and bias gets a value before any sample reads it.
	task automatic test_load_coefficients();
		for (int i = 0; i < WEIGHT_COUNT; i++)
			send_request(dwc3_pkg::ACT_WEIGHT, dwc3_pkg::INDEX_W'(i),
				dwc3_pkg::SAMPLE_W'($urandom), $urandom);
		for (int i = 0; i < MAX_CHANNELS; i++)
			send_request(dwc3_pkg::ACT_BIAS, dwc3_pkg::INDEX_W'(i),
				dwc3_pkg::SAMPLE_W'($urandom), $urandom);
	endtask

	// Extreme values, ignored loads and the unused action.
	task automatic test_edges_and_loads();
		write_channels(dwc3_pkg::CFG_W'(2));
		send_request(dwc3_pkg::ACT_WEIGHT, 10'd0, 8'h80, 32'h0);
		send_request(dwc3_pkg::ACT_WEIGHT, 10'd1, 8'h7F, 32'hFFFF_FFFF);
		send_request(dwc3_pkg::ACT_WEIGHT, 10'd575, 8'h7F, 32'h0);
		send_request(dwc3_pkg::ACT_WEIGHT, 10'd576, 8'h01, 32'h0);
		send_request(dwc3_pkg::ACT_WEIGHT, 10'd1023, 8'hFF, 32'h0);
		send_request(dwc3_pkg::ACT_BIAS, 10'd0, 8'h00, 32'h7FFF_FFFF);
		send_request(dwc3_pkg::ACT_BIAS, 10'd1, 8'hFF, 32'h8000_0000);
		send_request(dwc3_pkg::ACT_BIAS, 10'd63, 8'h00, 32'h0000_1234);
		send_request(dwc3_pkg::ACT_BIAS, 10'd64, 8'h00, 32'hFFFF_FFFF);
		send_request(dwc3_pkg::ACT_BIAS, 10'd1023, 8'h00, 32'hFFFF_FFFF);
		send_request(ACT_UNUSED, 10'h3FF, 8'hFF, 32'hFFFF_FFFF);
		send_sample(8'h80);
		send_sample(8'h7F);
		send_sample(8'h7F);
		send_sample(8'h80);
		send_sample(8'h00);
		send_sample(8'hFF);
		send_sample(8'h7F);
		send_sample(8'h80);
	endtask

	// Channel count at and beyond its limits, and changes in the middle of a pixel.
	task automatic test_channel_register();
		write_channels(dwc3_pkg::CFG_W'(0));
		repeat (5) send_sample(dwc3_pkg::SAMPLE_W'($urandom));
		write_channels(dwc3_pkg::CFG_W'(127));
		repeat (70) send_sample(dwc3_pkg::SAMPLE_W'($urandom));
		write_channels(dwc3_pkg::CFG_W'(65));
		repeat (6) send_sample(dwc3_pkg::SAMPLE_W'($urandom));
		write_channels(dwc3_pkg::CFG_W'(64));
		repeat (10) send_sample(dwc3_pkg::SAMPLE_W'($urandom));
		write_channels(dwc3_pkg::CFG_W'(3));
		repeat (6) send_sample(dwc3_pkg::SAMPLE_W'($urandom));
	endtask

	// One channel across several rows, with a long output stall while samples keep coming.
	task automatic test_output_stall();
		write_channels(dwc3_pkg::CFG_W'(1));
		for (int i = 0; i < STALL_ITEMS; i++) begin
			if (i == HOLD_AFTER)
				sink_hold = 1'b1;
			send_sample(dwc3_pkg::SAMPLE_W'($urandom));
		end
	endtask

	// Mixed samples and loads over several channel settings.
	task automatic test_random_traffic();
		int pick;
		int roll;
		logic [dwc3_pkg::CFG_W-1:0] setting;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			pick = $urandom_range(9);
			setting = (pick == 0) ? dwc3_pkg::CFG_W'(0) :
				(pick == 1) ? dwc3_pkg::CFG_W'(127) :
				(pick == 2) ? dwc3_pkg::CFG_W'(64) : dwc3_pkg::CFG_W'($urandom_range(8, 1));
			write_channels(setting);
			gaps_on = (phase != 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				roll = $urandom_range(99);
				if (roll < 84)
					send_sample(dwc3_pkg::SAMPLE_W'($urandom));
				else if (roll < 93)
					send_request(dwc3_pkg::ACT_WEIGHT,
						dwc3_pkg::INDEX_W'($urandom_range(WEIGHT_COUNT - 1)),
						dwc3_pkg::SAMPLE_W'($urandom), $urandom);
				else if (roll < 97)
					send_request(dwc3_pkg::ACT_BIAS,
						dwc3_pkg::INDEX_W'($urandom_range(MAX_CHANNELS - 1)),
						dwc3_pkg::SAMPLE_W'($urandom), $urandom);
				else if (roll < 98)
					send_request(ACT_UNUSED, dwc3_pkg::INDEX_W'($urandom),
						dwc3_pkg::SAMPLE_W'($urandom), $urandom);
				else if (roll < 99)
					send_request(dwc3_pkg::ACT_WEIGHT,
						dwc3_pkg::INDEX_W'($urandom_range(1023, WEIGHT_COUNT)),
						dwc3_pkg::SAMPLE_W'($urandom), $urandom);
				else
					send_request(dwc3_pkg::ACT_BIAS,
						dwc3_pkg::INDEX_W'($urandom_range(1023, MAX_CHANNELS)),
						dwc3_pkg::SAMPLE_W'($urandom), $urandom);
			end
		end
		gaps_on = 1'b1;
	endtask

	// Output side: random back-pressure, with one long hold-off on demand.
	initial begin : sink_ready
		int k;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold) begin
				sink_hold = 1'b0;
				m_axis_tready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++)
					@(negedge clk);
			end
			m_axis_tready <= !(gaps_on && $urandom_range(99) < 22);
		end
	end

	// Compare each result leaving the block with the oldest expectation.
	always @(posedge clk) begin : check_results
		dwc3_pkg::result_t got;
		dwc3_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tlast,
				m_axis_tdata[dwc3_pkg::ACT_OUT_W+dwc3_pkg::CHAN_OUT_W-1:0]};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("tb: unexpected result act %0d ch %0d end %0b",
						got.activation, got.channel, got.frame_end);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got.activation !== want.activation || got.channel !== want.channel ||
						got.frame_end !== want.frame_end) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("tb: mismatch: want act %0d ch %0d end %0b, got %0d %0d %0b",
							want.activation, want.channel, want.frame_end,
							got.activation, got.channel, got.frame_end);
				end
			end
		end
	end

	// Watchdog on cycles with no request, result or register write accepted.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: no progress for %0d cycles", STALL_LIMIT);
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	// Reset, then the tests in turn, then drain and report.
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		idle_cycles   = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_load_coefficients();
		test_edges_and_loads();
		test_channel_register();
		test_output_stall();
		test_random_traffic();

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d requests sent, %0d results checked, %0d frame ends, %0d mismatches",
			requests_sent, results_checked, frame_ends_due, mismatches);
		$display("tb: covered channel counts 0 to 127, ignored loads, row and column edges, output hold-off");
		if (mismatches == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
